[src/pixel_to_rgb10a2_packer_defines.svh]
// Assertion macros for the RGB10A2 pixel packer.
// Included by the packer top, which carries the concurrent assertions; needs clk and rst_n in scope.
`ifndef PIXEL_TO_RGB10A2_PACKER_DEFINES_SVH
`define PIXEL_TO_RGB10A2_PACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define P2R_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("p2r check failed");

// Next-cycle implication, disabled during reset.
`define P2R_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("p2r check failed");

`endif

[src/p2r_pkg.sv]
// Shared types and constants for the RGB10A2 pixel packer.
// No dependencies.
`default_nettype none
package p2r_pkg;

  localparam int unsigned NUM_STAGES = 4;

  localparam logic [1:0] FMT_BYTE = 2'd0;
  localparam logic [1:0] FMT_HALF = 2'd1;

  localparam logic [7:0] CFG_IDX_FORMAT = 8'd0;
  localparam logic [7:0] CFG_IDX_ATTEN  = 8'd1;

  typedef struct packed {
    logic [31:0] chan_zero;
    logic [31:0] chan_one;
    logic [31:0] chan_two;
    logic [31:0] chan_alpha;
    logic        row_last;
  } p2r_in_t;

  typedef struct packed {
    logic [31:0] packed_pixel;
    logic        row_end;
  } p2r_out_t;

  // Per-stage advance strobes plus the static mode bits each lane needs.
  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
    logic                  byte_mode;
    logic                  half_mode;
    logic                  atten;
  } p2r_ctrl_t;

endpackage
`default_nettype wire

[src/p2r_lane.sv]
// One channel lane of the packer: decode, scale multiply and byte-mode arithmetic, rounding, quantize.
// Depends on p2r_pkg; stage advance comes from the top level.
`default_nettype none
module p2r_lane import p2r_pkg::*; #(
  parameter bit IS_ALPHA = 1'b0
) (
  input  wire logic        clk,
  input  wire p2r_ctrl_t   ctrl,
  input  wire logic [31:0] raw,
  input  wire logic [7:0]  alpha_byte,
  output logic [9:0]       field
);

  localparam int unsigned SW    = IS_ALPHA ? 2 : 10;
  localparam int unsigned PW    = 24 + SW;
  localparam int unsigned SH_HI = PW - 24;
  localparam int unsigned SH_LO = PW - 25;
  localparam logic [SW-1:0] SCALE = IS_ALPHA ? SW'(3) : SW'(1023);
  localparam logic [9:0]    LIM   = IS_ALPHA ? 10'd3 : 10'd1023;

  // Stage 1: decode.
  logic [7:0]  exp_c;
  logic [23:0] man_c;
  logic        zero_c, big_c, nan_c, sign_c;
  logic [15:0] bx_c;

  always_comb begin
    if (ctrl.half_mode) begin
      sign_c = raw[15];
      nan_c  = (raw[14:10] == 5'd31) && (raw[9:0] != 10'd0);
      exp_c  = 8'({3'd0, raw[14:10]} + 8'd112);
      man_c  = {1'b1, raw[9:0], 13'd0};
      zero_c = (raw[14:10] == 5'd0);
    end else begin
      sign_c = raw[31];
      nan_c  = (raw[30:23] == 8'd255) && (raw[22:0] != 23'd0);
      exp_c  = raw[30:23];
      man_c  = {1'b1, raw[22:0]};
      zero_c = (raw[30:23] < 8'd116);
    end
    zero_c = zero_c || nan_c || sign_c;
    big_c  = (exp_c >= 8'd127);
    if (!IS_ALPHA && ctrl.atten) begin
      bx_c = raw[7:0] * alpha_byte;
    end else begin
      bx_c = {8'd0, raw[7:0]};
    end
  end

  logic [7:0]  s1_exp_r;
  logic [23:0] s1_man_r;
  logic        s1_zero_r, s1_big_r;
  logic [15:0] s1_bx_r;

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      s1_exp_r  <= exp_c;
      s1_man_r  <= man_c;
      s1_zero_r <= zero_c;
      s1_big_r  <= big_c;
      s1_bx_r   <= bx_c;
    end
  end

  // Stage 2: scale multiply and byte-mode arithmetic.
  logic [9:0]  bfield_c;
  logic [16:0] div_x;
  logic [16:0] div_s;
  logic [9:0]  a3_c;

  always_comb begin
    div_x = {1'b0, s1_bx_r} + 17'd127;
    div_s = div_x + {8'd0, div_x[16:8]} + 17'd1;
    a3_c  = 10'({2'd0, s1_bx_r[7:0]} * 10'd3 + 10'd127);
    if (IS_ALPHA) begin
      bfield_c = {8'd0, a3_c[9:8]};
    end else if (ctrl.atten) begin
      bfield_c = {div_s[15:8], 2'b00};
    end else begin
      bfield_c = {s1_bx_r[7:0], 2'b00};
    end
  end

  logic [PW-1:0] s2_p_r;
  logic [7:0]    s2_exp_r;
  logic          s2_zero_r, s2_big_r;
  logic [9:0]    s2_bf_r;

  always_ff @(posedge clk) begin
    if (ctrl.adv[1]) begin
      s2_p_r    <= PW'(s1_man_r * SCALE);
      s2_exp_r  <= s1_exp_r;
      s2_zero_r <= s1_zero_r;
      s2_big_r  <= s1_big_r;
      s2_bf_r   <= bfield_c;
    end
  end

  // Stage 3: round the product to 24 significant bits, nearest even.
  logic [PW+1:0] pp;
  logic [23:0]   keep_c;
  logic          guard_c, sticky_c;
  logic [24:0]   rnd_c;
  logic [8:0]    shf_c;

  always_comb begin
    pp = {s2_p_r, 2'b00};
    if (s2_p_r[PW-1]) begin
      keep_c   = pp[PW+1:PW-22];
      guard_c  = pp[PW-23];
      sticky_c = |pp[PW-24:0];
      shf_c    = 9'd149 - 9'(SH_HI) - {1'b0, s2_exp_r};
    end else begin
      keep_c   = pp[PW:PW-23];
      guard_c  = pp[PW-24];
      sticky_c = |pp[PW-25:0];
      shf_c    = 9'd149 - 9'(SH_LO) - {1'b0, s2_exp_r};
    end
    rnd_c = {1'b0, keep_c} + {24'd0, guard_c & (sticky_c | keep_c[0])};
  end

  // The alpha lane can need a shift of up to 35 places, so six bits are kept.
  logic [24:0] s3_r_r;
  logic [5:0]  s3_shf_r;
  logic        s3_zero_r, s3_big_r;
  logic [9:0]  s3_bf_r;

  always_ff @(posedge clk) begin
    if (ctrl.adv[2]) begin
      s3_r_r    <= rnd_c;
      s3_shf_r  <= shf_c[5:0];
      s3_zero_r <= s2_zero_r;
      s3_big_r  <= s2_big_r;
      s3_bf_r   <= s2_bf_r;
    end
  end

  // Stage 4: q holds floor(2p); halving after +1 rounds half away from zero.
  logic [24:0] q_c;
  logic [25:0] t_c;
  logic [9:0]  ff_c;

  always_comb begin
    q_c = s3_r_r >> s3_shf_r;
    t_c = ({1'b0, q_c} + 26'd1) >> 1;
    if (s3_zero_r) begin
      ff_c = 10'd0;
    end else if (s3_big_r || t_c > {16'd0, LIM}) begin
      ff_c = LIM;
    end else begin
      ff_c = t_c[9:0];
    end
  end

  logic [9:0] s4_field_r;

  always_ff @(posedge clk) begin
    if (ctrl.adv[3]) begin
      s4_field_r <= ctrl.byte_mode ? s3_bf_r : ff_c;
    end
  end

  assign field = s4_field_r;

endmodule
`default_nettype wire

[src/pixel_to_rgb10a2_packer.sv]
// RGB10A2 packer: a pixel reaches out_valid through four registered stages.
// Throughput one pixel per cycle absent stalls; the four lanes share one stall chain.
// Reset (rst_n low, synchronous) empties the pipeline and clears both registers to 0.
// Configuration writes are taken in every cycle and land at once.
`default_nettype none
`include "pixel_to_rgb10a2_packer_defines.svh"
module pixel_to_rgb10a2_packer import p2r_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire p2r_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output p2r_out_t      out_data,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration registers. The source format code 3 acts as single precision.
  logic [1:0] fmt_r;
  logic       atten_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_BYTE;
      atten_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_FORMAT) begin
        fmt_r <= cfg_data[1:0];
      end else if (cfg_index == CFG_IDX_ATTEN) begin
        atten_r <= cfg_data[0];
      end
    end
  end

  // Stall chain: a stage may load when it is empty or its successor moves.
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] rdy;
  p2r_ctrl_t             ctrl;

  always_comb begin
    rdy[NUM_STAGES-1] = out_ready || !vld_r[NUM_STAGES-1];
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    ctrl.adv       = rdy;
    ctrl.byte_mode = (fmt_r == FMT_BYTE);
    ctrl.half_mode = (fmt_r == FMT_HALF);
    ctrl.atten     = atten_r;
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // The row marker rides along beside the lanes.
  logic [NUM_STAGES-1:0] last_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      last_r[0] <= in_data.row_last;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (rdy[i]) begin
        last_r[i] <= last_r[i-1];
      end
    end
  end

  logic [9:0] f0, f1, f2, fa;

  p2r_lane #(.IS_ALPHA(1'b0)) u_lane0 (
    .clk(clk), .ctrl(ctrl), .raw(in_data.chan_zero),
    .alpha_byte(in_data.chan_alpha[7:0]), .field(f0));
  p2r_lane #(.IS_ALPHA(1'b0)) u_lane1 (
    .clk(clk), .ctrl(ctrl), .raw(in_data.chan_one),
    .alpha_byte(in_data.chan_alpha[7:0]), .field(f1));
  p2r_lane #(.IS_ALPHA(1'b0)) u_lane2 (
    .clk(clk), .ctrl(ctrl), .raw(in_data.chan_two),
    .alpha_byte(in_data.chan_alpha[7:0]), .field(f2));
  p2r_lane #(.IS_ALPHA(1'b1)) u_lanea (
    .clk(clk), .ctrl(ctrl), .raw(in_data.chan_alpha),
    .alpha_byte(in_data.chan_alpha[7:0]), .field(fa));

  assign out_valid             = vld_r[NUM_STAGES-1];
  assign out_data.packed_pixel = {fa[1:0], f2, f1, f0};
  assign out_data.row_end      = last_r[NUM_STAGES-1];

  // An accepted transfer always occupies the first stage next cycle.
  `P2R_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, vld_r[0])
  // Input back-pressure appears only when every stage holds a pixel.
  `P2R_ASSERT_NOW(a_stall_full, !in_ready, &vld_r)
  // A drained output with nothing behind it empties the last stage.
  `P2R_ASSERT_NEXT(a_drain, out_valid && out_ready && !vld_r[NUM_STAGES-2], !out_valid)

endmodule
`default_nettype wire

[tb/tb_pixel_to_rgb10a2_packer.sv]
// Self-checking testbench for the RGB10A2 pixel packer: random and directed pixels
// in byte, half and single formats, checked against an integer-exact predictor.
// Depends on p2r_pkg and the pixel_to_rgb10a2_packer RTL.
`default_nettype none
module tb_pixel_to_rgb10a2_packer;
  import p2r_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Format codes that the package leaves out; format three acts as single.
  localparam logic [1:0] FMT_SINGLE     = 2'd2;
  localparam logic [1:0] FMT_SINGLE_ALT = 2'd3;
  // An index past the last register; the block must ignore writes to it.
  localparam logic [7:0] CFG_IDX_UNUSED = 8'd9;
  localparam int unsigned COLOR_LIM = 1023;
  localparam int unsigned ALPHA_LIM = 3;
  localparam int unsigned PIPE_DEPTH = NUM_STAGES;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  p2r_in_t in_data;
  logic out_valid, out_ready;
  p2r_out_t out_data;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_index;
  logic [31:0] cfg_data;

  pixel_to_rgb10a2_packer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Configuration as the block should hold it after each accepted write.
  logic [1:0] fmt_shadow;
  logic atten_shadow;

  p2r_in_t pixels_to_send[$];   // pixels waiting for the driver
  p2r_out_t words_expected[$];  // packed words the block still owes us
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;    // set by the sequencer, consumed by the receiver
  int unsigned hold_left;
  logic in_taken;
  int errors;
  longint unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Splits a raw channel into sign, class and an exact mantissa/exponent pair
  // so that value = mant * 2^expo with no rounding at all.
  function automatic void split_channel(input logic [31:0] raw, input logic [1:0] fmt,
                                        output bit neg, output bit is_inf, output bit is_nan,
                                        output longint unsigned mant, output int expo);
    logic [15:0] h;
    h = raw[15:0];
    is_inf = 1'b0;
    is_nan = 1'b0;
    if (fmt == FMT_HALF) begin
      neg = h[15];
      if (h[14:10] == 5'd31) begin
        is_inf = (h[9:0] == 0);
        is_nan = (h[9:0] != 0);
        mant = 0;
        expo = 0;
      end else if (h[14:10] == 5'd0) begin
        mant = h[9:0];
        expo = -24;
      end else begin
        mant = {1'b1, h[9:0]};
        expo = int'(h[14:10]) - 25;
      end
    end else begin
      neg = raw[31];
      if (raw[30:23] == 8'hFF) begin
        is_inf = (raw[22:0] == 0);
        is_nan = (raw[22:0] != 0);
        mant = 0;
        expo = 0;
      end else if (raw[30:23] == 8'h00) begin
        mant = raw[22:0];
        expo = -149;
      end else begin
        mant = {1'b1, raw[22:0]};
        expo = int'(raw[30:23]) - 150;
      end
    end
  endfunction

  // Single-precision product rounded to nearest even, then rounded half away
  // from zero to an integer and clamped to 0..lim. NaN and negatives give 0.
  function automatic logic [9:0] quantize_channel(input logic [31:0] raw,
                                                  input logic [1:0] fmt,
                                                  input int unsigned scale,
                                                  input int unsigned lim);
    bit neg, is_inf, is_nan;
    longint unsigned mant, prod, rem, half, t;
    int expo, len, sh;
    split_channel(raw, fmt, neg, is_inf, is_nan, mant, expo);
    if (is_nan) return 10'd0;
    if (neg) return 10'd0;
    if (is_inf) return lim[9:0];
    if (mant == 0) return 10'd0;
    prod = mant * scale;
    len = 0;
    while ((prod >> len) != 0) len++;
    if (len > 24) begin
      sh = len - 24;
      rem = prod & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      prod = prod >> sh;
      if (rem > half || (rem == half && prod[0])) prod++;
      prod = prod << sh;
    end
    if (expo >= 0) return lim[9:0];
    sh = -expo;
    if (sh >= 40) return 10'd0;
    t = prod >> sh;
    if ((prod & ((64'd1 << sh) - 1)) >= (64'd1 << (sh - 1))) t++;
    if (t > lim) t = lim;
    return t[9:0];
  endfunction

  function automatic p2r_out_t pack_pixel(input p2r_in_t px);
    p2r_out_t w;
    logic [9:0] c[3];
    logic [1:0] a;
    logic [31:0] raw[3];
    int unsigned v, alpha;
    raw[0] = px.chan_zero;
    raw[1] = px.chan_one;
    raw[2] = px.chan_two;
    if (fmt_shadow == FMT_BYTE) begin
      alpha = 32'(px.chan_alpha[7:0]);
      for (int i = 0; i < 3; i++) begin
        v = 32'(raw[i][7:0]);
        if (atten_shadow) v = (v * alpha + 127) / 255;
        c[i] = 10'(v * 4);
      end
      a = 2'((alpha * 3 + 127) >> 8);
    end else begin
      for (int i = 0; i < 3; i++) c[i] = quantize_channel(raw[i], fmt_shadow, 1023, COLOR_LIM);
      a = 2'(quantize_channel(px.chan_alpha, fmt_shadow, 3, ALPHA_LIM));
    end
    w.packed_pixel = {a, c[2], c[1], c[0]};
    w.row_end = px.row_last;
    return w;
  endfunction

  // Driver: a pixel stays on the bus until its transfer; the next one is
  // chosen at the falling edge that follows.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pixels_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus long hold-offs on request, counted
  // here so the sender keeps offering pixels and the pipeline backs up.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_request;
      hold_request <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every input transfer and checks every output transfer.
  always @(posedge clk) begin
    p2r_out_t exp_w;
    in_taken <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) words_expected.push_back(pack_pixel(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (words_expected.size() == 0) begin
        $display("%0t: unexpected output word %h row_end %b", $time,
                 out_data.packed_pixel, out_data.row_end);
        errors++;
      end else begin
        exp_w = words_expected.pop_front();
        if (out_data.packed_pixel !== exp_w.packed_pixel) begin
          $display("%0t: packed_pixel expected %h actual %h", $time,
                   exp_w.packed_pixel, out_data.packed_pixel);
          errors++;
        end
        if (out_data.row_end !== exp_w.row_end) begin
          $display("%0t: row_end expected %b actual %b", $time,
                   exp_w.row_end, out_data.row_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_pixel_to_rgb10a2_packer NOT OK");
      $finish;
    end
  end

  task automatic write_register(input logic [7:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IDX_FORMAT) fmt_shadow = value[1:0];
    else if (idx == CFG_IDX_ATTEN) atten_shadow = value[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lets every pending pixel through, then gives the pipeline time to settle.
  task automatic drain();
    while (pixels_to_send.size() != 0 || in_valid || words_expected.size() != 0)
      @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic queue_pixel(input logic [31:0] c0, c1, c2, ca, input logic last);
    p2r_in_t px;
    px.chan_zero = c0;
    px.chan_one = c1;
    px.chan_two = c2;
    px.chan_alpha = ca;
    px.row_last = last;
    pixels_to_send.push_back(px);
  endtask

  // Random channel bits: mostly values in or near 0..1 for the float formats
  // so rounding is exercised, with fully random patterns mixed in.
  function automatic logic [31:0] random_channel(input logic [1:0] fmt);
    logic [31:0] r;
    r = $urandom;
    if (fmt == FMT_BYTE) return r;
    case ($urandom_range(9))
      0, 1: return r;
      2: return {r[31:23], 8'd0, r[14:1], 1'b0} & ((fmt == FMT_HALF) ? 32'hFFFF_7C00 : 32'h807F_FFFF);
      default: begin
        if (fmt == FMT_HALF) return {r[31:16], 1'b0, 5'($urandom_range(15)), r[9:0]};
        return {1'b0, 8'($urandom_range(127, 110)), r[22:0]};
      end
    endcase
  endfunction

  task automatic random_pixels(input int n);
    for (int i = 0; i < n; i++)
      queue_pixel(random_channel(fmt_shadow), random_channel(fmt_shadow),
                  random_channel(fmt_shadow), random_channel(fmt_shadow),
                  1'($urandom_range(1)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_taken = 1'b0;
    errors = 0;
    cycles = 0;
    hold_request = 0;
    hold_left = 0;
    fmt_shadow = FMT_BYTE;
    atten_shadow = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 48;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Byte mode with reset configuration: extremes and ignored high bits.
    queue_pixel(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    queue_pixel(32'hFF, 32'hFF, 32'hFF, 32'hFF, 1'b1);
    queue_pixel(32'hFFFF_FF00, 32'h1234_5680, 32'hAAAA_AA55, 32'hDEAD_BE80, 1'b0);
    random_pixels(270);
    drain();

    // Premultiplied bytes; a stray index must not disturb anything.
    write_register(CFG_IDX_ATTEN, 32'h1);
    write_register(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
    queue_pixel(32'hFF, 32'h80, 32'h01, 32'h00, 1'b1);
    queue_pixel(32'hFF, 32'h80, 32'h01, 32'hFF, 1'b0);
    queue_pixel(32'hFF, 32'h7F, 32'h02, 32'h55, 1'b1);
    random_pixels(280);
    hold_request = 300;  // long receiver stall so the input side backs up
    drain();

    // Half floats, then with the byte-only premultiply bit cleared again.
    write_register(CFG_IDX_FORMAT, {30'd0, FMT_HALF});
    queue_pixel(32'h0000, 32'h8000, 32'h3C00, 32'h3800, 1'b0);  // 0, -0, 1.0, 0.5
    queue_pixel(32'h7C00, 32'hFC00, 32'h7E00, 32'h4000, 1'b1);  // inf, -inf, NaN, 2.0
    queue_pixel(32'hFFFF_0001, 32'h03FF, 32'hB800, 32'h3555, 1'b0);  // subnormals, -0.5
    random_pixels(270);
    drain();
    write_register(CFG_IDX_ATTEN, 32'hFFFF_FFFE);  // masks to 0

    send_idle_pct = 48;
    recv_idle_pct = 15;
    random_pixels(270);
    drain();

    // Single floats.
    write_register(CFG_IDX_FORMAT, {30'd0, FMT_SINGLE});
    queue_pixel(32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F00_0000, 1'b0);
    queue_pixel(32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'h7F7F_FFFF, 1'b1);
    queue_pixel(32'h0000_0001, 32'h3A00_2004, 32'hBF00_0000, 32'h3E2A_AAAB, 1'b0);
    random_pixels(270);
    drain();

    // Format three behaves as single; premultiply must still have no effect.
    write_register(CFG_IDX_FORMAT, {30'd0, FMT_SINGLE_ALT});
    write_register(CFG_IDX_ATTEN, 32'h1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_pixel(32'h3F80_0000, 32'h3F00_0000, 32'h3A80_4020, 32'h4040_0000, 1'b1);
    random_pixels(280);
    drain();

    // Masked format write lands on single again.
    write_register(CFG_IDX_FORMAT, 32'hFFFF_FFFE);
    random_pixels(300);
    drain();

    if (errors == 0 && words_expected.size() == 0) begin
      $display("tb_pixel_to_rgb10a2_packer OK");
    end else begin
      $display("tb_pixel_to_rgb10a2_packer NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
